@@ hw/rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int FREQ_W = 20;
   localparam int LEN_W  = 16;
   localparam int CMP_W  = 19;

   // request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_WRITE    = 3'd1;
   localparam logic [2:0] REQ_PLAY     = 3'd2;
   localparam logic [2:0] REQ_TONE_ON  = 3'd3;
   localparam logic [2:0] REQ_TONE_OFF = 3'd4;

   localparam logic [FREQ_W-1:0] TIMER_CLOCK_HZ = 20'd1000000;
   localparam logic [FREQ_W-1:0] MIN_PERIOD     = 20'd2;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [3:0]        slot;
      logic [FREQ_W-1:0] note_freq;
      logic [LEN_W-1:0]  note_length_ms;
      logic [7:0]        seq_length;
   } tsp_req_type;

   typedef struct packed {
      logic              pwm_running;
      logic [FREQ_W-1:0] reload_value;
      logic [CMP_W-1:0]  compare_value;
      logic              sequence_running;
   } tsp_rsp_type;

   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] divisor;
   } tsp_div_req_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] quotient;
   } tsp_div_rsp_type;

endpackage

@@ hw/rtl/tsp_divider.sv @@
// ----------------------------------------------------------------------------
// tsp_divider
// Restoring divider: timer clock rate over a frequency, one quotient bit
// per cycle. done pulses one cycle with the quotient; divisor must be nonzero.
// ----------------------------------------------------------------------------
module tsp_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  tsp_pkg::tsp_div_req_type  div_req,
   output tsp_pkg::tsp_div_rsp_type  div_rsp
);

   localparam int W = tsp_pkg::FREQ_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = tsp_pkg::TIMER_CLOCK_HZ;
         div_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ hw/rtl/tone_sequence_player_core.sv @@
// ----------------------------------------------------------------------------
// tone_sequence_player_core
// Plays a note table as PWM reload/compare settings. Each request transfer
// yields exactly one response showing the state after the request. The block
// takes one request at a time; any request that starts a tone waits on the
// shared 20-step divider that forms 1 MHz / frequency. The note table is a
// small memory with a registered read port and needs no clearing after reset.
// ----------------------------------------------------------------------------
module tone_sequence_player_core #(
   parameter int NOTE_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tsp_pkg::tsp_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tsp_pkg::tsp_rsp_type  rsp_data
);

   localparam int FW    = tsp_pkg::FREQ_W;
   localparam int LW    = tsp_pkg::LEN_W;
   localparam int CW    = tsp_pkg::CMP_W;
   localparam int POS_W = $clog2(NOTE_SLOTS + 1);
   localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam logic [8:0] SLOTS_9 = 9'(NOTE_SLOTS);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_DECODE     = 3'd1;
   localparam logic [2:0] ST_LEN_CHECK  = 3'd2;
   localparam logic [2:0] ST_NOTE_WAIT  = 3'd3;
   localparam logic [2:0] ST_NOTE_START = 3'd4;
   localparam logic [2:0] ST_DIVIDE     = 3'd5;
   localparam logic [2:0] ST_FINISH     = 3'd6;

   logic [2:0]          state_ff, state_in;
   tsp_pkg::tsp_req_type req_ff, req_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    total_ff, total_in;
   logic [LW-1:0]       elapsed_ff, elapsed_in;
   logic                playing_ff, playing_in;
   logic                pwm_on_ff, pwm_on_in;
   logic [FW-1:0]       reload_ff, reload_in;
   logic [CW-1:0]       compare_ff, compare_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tsp_pkg::tsp_rsp_type rsp_data_ff, rsp_data_in;

   logic [FW+LW-1:0]    note_mem [NOTE_SLOTS];
   logic [FW+LW-1:0]    rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    wr_idx;
   logic [FW-1:0]       rd_freq;
   logic [LW-1:0]       rd_len;
   logic [POS_W-1:0]    next_pos;
   logic [FW-1:0]       period;

   tsp_pkg::tsp_div_req_type div_req;
   tsp_pkg::tsp_div_rsp_type div_rsp;

   tsp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_freq  = rd_data_ff[FW+LW-1:LW];
   assign rd_len   = rd_data_ff[LW-1:0];
   assign next_pos = pos_ff + POS_W'(1);
   assign wr_idx   = IDX_W'(req_ff.slot);
   assign period   = (div_rsp.quotient < tsp_pkg::MIN_PERIOD) ?
                     tsp_pkg::MIN_PERIOD : div_rsp.quotient;

   assign mem_we = (state_ff == ST_DECODE) && (req_ff.req_type == tsp_pkg::REQ_WRITE) &&
                   ({5'd0, req_ff.slot} < SLOTS_9);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         note_mem[wr_idx] <= {req_ff.note_freq, req_ff.note_length_ms};
      end
      rd_data_ff <= note_mem[pos_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      elapsed_in   = elapsed_ff;
      playing_in   = playing_ff;
      pwm_on_in    = pwm_on_ff;
      reload_in    = reload_ff;
      compare_in   = compare_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_req.start   = 1'b0;
      div_req.divisor = req_ff.note_freq;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            case (req_ff.req_type)
               tsp_pkg::REQ_TICK: begin
                  if (playing_ff) begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + LW'(1);
                     end
                     state_in = ST_LEN_CHECK;
                  end
               end
               tsp_pkg::REQ_PLAY: begin
                  if (req_ff.seq_length == 8'd0) begin
                     playing_in = 1'b0;
                     total_in   = '0;
                     pos_in     = '0;
                     elapsed_in = '0;
                     pwm_on_in  = 1'b0;
                     compare_in = '0;
                  end else begin
                     total_in   = ({1'b0, req_ff.seq_length} < SLOTS_9) ?
                                  POS_W'(req_ff.seq_length) : POS_W'(NOTE_SLOTS);
                     pos_in     = '0;
                     playing_in = 1'b1;
                     state_in   = ST_NOTE_WAIT;
                  end
               end
               tsp_pkg::REQ_TONE_ON: begin
                  if (!playing_ff && (req_ff.note_freq != '0)) begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIVIDE;
                  end
               end
               tsp_pkg::REQ_TONE_OFF: begin
                  if (!playing_ff) begin
                     pwm_on_in  = 1'b0;
                     compare_in = '0;
                  end
               end
               default: begin
                  // writes go straight to the table; unknown codes do nothing
               end
            endcase
         end
         ST_LEN_CHECK: begin
            state_in = ST_FINISH;
            if (elapsed_ff >= rd_len) begin
               if (next_pos >= total_ff) begin
                  playing_in = 1'b0;
                  total_in   = '0;
                  pos_in     = '0;
                  elapsed_in = '0;
                  pwm_on_in  = 1'b0;
                  compare_in = '0;
               end else begin
                  pos_in   = next_pos;
                  state_in = ST_NOTE_WAIT;
               end
            end
         end
         ST_NOTE_WAIT: begin
            // table read at the new position is registered here for ST_NOTE_START
            state_in = ST_NOTE_START;
         end
         ST_NOTE_START: begin
            elapsed_in = '0;
            if (rd_freq == '0) begin
               pwm_on_in  = 1'b0;
               compare_in = '0;
               state_in   = ST_FINISH;
            end else begin
               div_req.start   = 1'b1;
               div_req.divisor = rd_freq;
               state_in        = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               reload_in  = period - FW'(1);
               compare_in = period[FW-1:1];
               pwm_on_in  = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.pwm_running      = pwm_on_ff;
               rsp_data_in.reload_value     = reload_ff;
               rsp_data_in.compare_value    = compare_ff;
               rsp_data_in.sequence_running = playing_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         total_ff     <= '0;
         elapsed_ff   <= '0;
         playing_ff   <= 1'b0;
         pwm_on_ff    <= 1'b0;
         reload_ff    <= '0;
         compare_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         elapsed_ff   <= elapsed_in;
         playing_ff   <= playing_in;
         pwm_on_ff    <= pwm_on_in;
         reload_ff    <= reload_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/tsp_checker.sv @@
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tone sequence player, bound to tone_sequence_player_core.
// ----------------------------------------------------------------------------
module tsp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tsp_pkg::tsp_rsp_type  rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request at a time: a transfer makes the port busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port not busy after transfer");

   a_stopped_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pwm_running |-> rsp_data.compare_value == '0)
      else $error("compare nonzero while stopped");

   // reload and compare come from the same period
   a_period_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pwm_running |->
         ({1'b0, rsp_data.compare_value, 1'b0} == ({1'b0, rsp_data.reload_value} + 21'd1)) ||
         ({1'b0, rsp_data.compare_value, 1'b1} == ({1'b0, rsp_data.reload_value} + 21'd1)))
      else $error("reload and compare disagree");

endmodule

bind tone_sequence_player_core tsp_checker u_tsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tone_sequence_player_core. A short table of
// directed requests is followed by random songs (slot writes, a play and a
// run of millisecond ticks) mixed with loose requests. Each response is compared
// with the behavioral player model in this file or, for typed rows, a fixed value.
// ----------------------------------------------------------------------------
module tb_top;
   import tsp_pkg::*;

   localparam int          NOTE_SLOTS      = 16;
   localparam int          ITEM_TARGET     = 1600;
   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tsp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tsp_rsp_type rsp_data;

   tone_sequence_player_core #(.NOTE_SLOTS(NOTE_SLOTS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---- player model state ----
   logic [FREQ_W-1:0] tbl_freq [NOTE_SLOTS] = '{default: '0};
   logic [LEN_W-1:0]  tbl_len  [NOTE_SLOTS] = '{default: '0};
   bit                slot_written [NOTE_SLOTS] = '{default: 1'b0};
   logic [4:0]        cur_note     = '0;   // one bit wider so it can pass the last slot
   logic [4:0]        seq_total    = '0;
   logic [LEN_W-1:0]  note_ms      = '0;
   logic              seq_on       = 1'b0;
   logic              tone_on      = 1'b0;
   logic [FREQ_W-1:0] tone_reload  = '0;
   logic [CMP_W-1:0]  tone_compare = '0;

   tsp_rsp_type expected_tones [$];
   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          burst_left     = 0;

   function automatic void apply_tone(logic [FREQ_W-1:0] freq);
      logic [FREQ_W-1:0] period;
      if (freq != '0) begin
         period = TIMER_CLOCK_HZ / freq;
         if (period < MIN_PERIOD)
            period = MIN_PERIOD;
         tone_reload  = period - 1'b1;
         tone_compare = CMP_W'(period >> 1);
         tone_on      = 1'b1;
      end
   endfunction

   function automatic void halt_tone();
      tone_on      = 1'b0;
      tone_compare = '0;
   endfunction

   function automatic void stop_player();
      seq_on     = 1'b0;
      seq_total  = '0;
      cur_note   = '0;
      note_ms    = '0;
      halt_tone();
   endfunction

   function automatic void enter_note();
      if (cur_note < seq_total && cur_note < NOTE_SLOTS) begin
         note_ms = '0;
         if (tbl_freq[cur_note[3:0]] == '0)
            halt_tone();
         else
            apply_tone(tbl_freq[cur_note[3:0]]);
      end
   endfunction

   function automatic tsp_rsp_type predict_player(tsp_req_type r);
      tsp_rsp_type o;
      case (r.req_type)
         REQ_TICK: begin
            if (seq_on) begin
               if (note_ms != '1)
                  note_ms = note_ms + 1'b1;
               if (note_ms >= tbl_len[cur_note[3:0]]) begin
                  cur_note = cur_note + 1'b1;
                  if (cur_note >= seq_total)
                     stop_player();
                  else
                     enter_note();
               end
            end
         end
         REQ_WRITE: begin
            tbl_freq[r.slot]     = r.note_freq;
            tbl_len[r.slot]      = r.note_length_ms;
            slot_written[r.slot] = 1'b1;
         end
         REQ_PLAY: begin
            if (r.seq_length == '0) begin
               stop_player();
            end else begin
               seq_total  = (r.seq_length < NOTE_SLOTS) ? 5'(r.seq_length) : 5'(NOTE_SLOTS);
               cur_note   = '0;
               seq_on     = 1'b1;
               enter_note();
            end
         end
         REQ_TONE_ON: begin
            if (!seq_on)
               apply_tone(r.note_freq);
         end
         REQ_TONE_OFF: begin
            if (!seq_on)
               halt_tone();
         end
         default: ;
      endcase
      o.pwm_running      = tone_on;
      o.reload_value     = tone_reload;
      o.compare_value    = tone_compare;
      o.sequence_running = seq_on;
      return o;
   endfunction

   // slots 0..n-1 all written: a play may cover at most that many notes
   function automatic int written_prefix();
      int n;
      n = 0;
      while (n < NOTE_SLOTS && slot_written[n])
         n++;
      return n;
   endfunction

   // ---- stimulus helpers ----
   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return FREQ_W'($urandom_range(1, 20));
         2:       return FREQ_W'($urandom_range(20, 5000));
         3:       return FREQ_W'($urandom_range(499990, 500010));
         4:       return FREQ_W'($urandom_range(900000, 1048575));
         default: return FREQ_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      case ($urandom_range(0, 9))
         0:          return LEN_W'($urandom);
         1, 2, 3:    return LEN_W'($urandom_range(4, 12));
         default:    return LEN_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic tsp_req_type rand_req();
      tsp_req_type r;
      r.req_type       = 3'($urandom_range(0, 7));
      r.slot           = 4'($urandom);
      r.note_freq      = ($urandom_range(0, 1) == 0) ? pick_freq() : FREQ_W'($urandom);
      r.note_length_ms = LEN_W'($urandom);
      r.seq_length     = 8'($urandom);
      return r;
   endfunction

   // offer one request, hold it until taken, then queue its expected response
   task automatic offer(tsp_req_type r, bit typed, tsp_rsp_type typed_rsp);
      tsp_rsp_type want;
      int gap;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      want = predict_player(r);
      expected_tones.push_back(typed ? typed_rsp : want);
      if (r.req_type <= REQ_TONE_OFF)
         items_sent++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic loose_request();
      tsp_req_type r;
      int n;
      r = rand_req();
      n = written_prefix();
      if (r.req_type == REQ_PLAY && n < NOTE_SLOTS)
         r.seq_length = 8'($urandom_range(0, n));
      offer(r, 1'b0, '0);
   endtask

   // write a run of slots from 0, play them, then feed ticks with some noise
   task automatic play_song();
      tsp_req_type r;
      int k, n_ticks, j;
      k = ($urandom_range(0, 3) == 0) ? NOTE_SLOTS : $urandom_range(1, 6);
      for (j = 0; j < k; j++) begin
         r                = rand_req();
         r.req_type       = REQ_WRITE;
         r.slot           = 4'(j);
         r.note_freq      = pick_freq();
         r.note_length_ms = pick_len();
         offer(r, 1'b0, '0);
      end
      r          = rand_req();
      r.req_type = REQ_PLAY;
      if (k == NOTE_SLOTS && $urandom_range(0, 1) == 0)
         r.seq_length = 8'($urandom_range(NOTE_SLOTS, 255));
      else
         r.seq_length = 8'($urandom_range(1, k));
      offer(r, 1'b0, '0);
      n_ticks = $urandom_range(5, 60);
      for (j = 0; j < n_ticks; j++) begin
         if (!seq_on && $urandom_range(0, 2) == 0)
            break;
         r = rand_req();
         case ($urandom_range(0, 19))
            0, 1: r.req_type = REQ_TONE_ON;
            2:    r.req_type = REQ_TONE_OFF;
            3:    r.req_type = REQ_WRITE;
            4:    r.req_type = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            default: r.req_type = REQ_TICK;
         endcase
         offer(r, 1'b0, '0);
      end
      if (seq_on && $urandom_range(0, 2) == 0) begin
         r              = rand_req();
         r.req_type     = REQ_PLAY;
         r.seq_length   = '0;
         offer(r, 1'b0, '0);
      end
   endtask

   // ---- directed table ----
   typedef struct {
      tsp_req_type req;
      bit          typed;
      tsp_rsp_type rsp;
   } steer_row_type;

   steer_row_type steer_rows [$];

   function automatic void add_row(logic [2:0] kind, logic [3:0] slot,
                                   logic [FREQ_W-1:0] freq, logic [LEN_W-1:0] len_ms,
                                   logic [7:0] seq, bit typed, logic pwm,
                                   logic [FREQ_W-1:0] reload, logic [CMP_W-1:0] cmp,
                                   logic running);
      steer_row_type row;
      row.req.req_type             = kind;
      row.req.slot                 = slot;
      row.req.note_freq            = freq;
      row.req.note_length_ms       = len_ms;
      row.req.seq_length           = seq;
      row.typed                    = typed;
      row.rsp.pwm_running          = pwm;
      row.rsp.reload_value         = reload;
      row.rsp.compare_value        = cmp;
      row.rsp.sequence_running     = running;
      steer_rows.push_back(row);
   endfunction

   // ---- response side: check and stall pattern ----
   task automatic check_tone(tsp_rsp_type got);
      tsp_rsp_type want;
      if (expected_tones.size() == 0) begin
         $error("response with nothing expected: %p", got);
         mismatch_count++;
      end else begin
         want = expected_tones.pop_front();
         if (got.pwm_running !== want.pwm_running) begin
            $error("pwm_running: expected %0d, got %0d", want.pwm_running, got.pwm_running);
            mismatch_count++;
         end
         if (got.reload_value !== want.reload_value) begin
            $error("reload_value: expected %0d, got %0d", want.reload_value,
                   got.reload_value);
            mismatch_count++;
         end
         if (got.compare_value !== want.compare_value) begin
            $error("compare_value: expected %0d, got %0d", want.compare_value,
                   got.compare_value);
            mismatch_count++;
         end
         if (got.sequence_running !== want.sequence_running) begin
            $error("sequence_running: expected %0d, got %0d", want.sequence_running,
                   got.sequence_running);
            mismatch_count++;
         end
      end
   endtask

   initial begin : rsp_side
      int unsigned cyc;
      int unsigned hold_left;
      logic        stall_nx;
      cyc       = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            check_tone(rsp_data);
         cyc++;
         // long hold-off so the block backs up and stalls its input
         if (cyc % 8000 == 2000)
            hold_left = HOLD_CYCLES;
         if (hold_left != 0) begin
            stall_nx = 1'b1;
            hold_left--;
         end else begin
            case ((cyc >> 8) % 4)
               0:       stall_nx = 1'b0;
               1:       stall_nx = 1'($urandom_range(0, 1));
               2:       stall_nx = (cyc % 3 == 0);
               default: stall_nx = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_stall <= stall_nx;
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // ---- main sequence ----
   initial begin : stimulus
      int next_drain;
      next_drain = 500;

      // state after reset, tone extremes and clamping, ignored requests
      add_row(REQ_TICK,        4'd0,  20'd0,       16'd0,     8'd0,   1, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TONE_OFF,    4'd0,  20'd0,       16'd0,     8'd0,   1, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TONE_ON,     4'd0,  20'd0,       16'd0,     8'd0,   1, 0, 20'd0,      19'd0,      0);
      add_row(REQ_SPARE_LAST,  4'd3,  20'd1000,    16'd5,     8'd4,   1, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TONE_ON,     4'd0,  20'd1,       16'd0,     8'd0,   1, 1, 20'd999999, 19'd500000, 0);
      add_row(REQ_TONE_ON,     4'd0,  20'hFFFFF,   16'd0,     8'd0,   1, 1, 20'd1,      19'd1,      0);
      add_row(REQ_TONE_ON,     4'd0,  20'd333333,  16'd0,     8'd0,   1, 1, 20'd2,      19'd1,      0);
      add_row(REQ_TONE_ON,     4'd0,  20'd0,       16'd0,     8'd0,   1, 1, 20'd2,      19'd1,      0);
      add_row(REQ_TONE_OFF,    4'd0,  20'd0,       16'd0,     8'd0,   1, 0, 20'd2,      19'd0,      0);
      // a three note sequence with a rest and a maximal note
      add_row(REQ_WRITE,       4'd0,  20'd1000,    16'd2,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_WRITE,       4'd1,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_WRITE,       4'd2,  20'hFFFFF,   16'hFFFF,  8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_WRITE,       4'd15, 20'd440,     16'd1,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_PLAY,        4'd0,  20'd0,       16'd0,     8'd3,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TONE_OFF,    4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TONE_ON,     4'd0,  20'd1,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TICK,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TICK,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TICK,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_TICK,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_PLAY,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_PLAY,        4'd0,  20'd0,       16'd0,     8'd2,   0, 0, 20'd0,      19'd0,      0);
      add_row(REQ_PLAY,        4'd0,  20'd0,       16'd0,     8'd0,   0, 0, 20'd0,      19'd0,      0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steer_rows[i])
         offer(steer_rows[i].req, steer_rows[i].typed, steer_rows[i].rsp);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 7)
            play_song();
         else
            repeat ($urandom_range(1, 8)) loose_request();
         if (items_sent >= next_drain) begin
            // let every outstanding transfer come back before going on
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_tones.size() != 0);
            next_drain += 500;
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tones.size() != 0);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_divider.sv
hw/rtl/tone_sequence_player_core.sv
hw/rtl/tsp_checker.sv
test/tb_top.sv
